// File: rtl/core/fdsa_pkg.sv
// Shared constants, codes and state type for the file directory sector allocator.
// No dependencies.
package fdsa_pkg;

  localparam int unsigned DirEntries     = 16;
  localparam int unsigned SectorsPerFile = 26;
  localparam int unsigned NameBytes      = 6;
  localparam int unsigned MapSectors     = 256;
  localparam int unsigned ListDepth      = DirEntries * SectorsPerFile;

  localparam int unsigned EntryW  = $clog2(DirEntries);
  localparam int unsigned CountW  = 5;
  localparam int unsigned SecW    = 8;
  localparam int unsigned SecIdxW = 9;
  localparam int unsigned AddrW   = $clog2(ListDepth);
  localparam int unsigned NameW   = 48;

  localparam logic [SecIdxW-1:0] ResetReserved = 9'd3;

  typedef enum logic [1:0] {
    ActLookup = 2'd0,
    ActWrite  = 2'd1,
    ActDelete = 2'd2,
    ActNone   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StNoEntry  = 2'd2,
    StShort    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SFind,
    SDecide,
    SAlloc,
    SRead,
    SEmit,
    SOne
  } state_e;

endpackage

// File: rtl/core/file_directory_sector_allocator.sv
// Top level of the file directory sector allocator: directory scan, first-fit
// allocation and result sequencing. Depends on fdsa_pkg.
//
// A request is taken when start_i is high and busy_o is low; busy_o stays high
// until the last result has been formed. Every request with a used action first
// walks all 16 directory entries, one per cycle, then decides. Sectors are
// only freed by a write of reserved_sectors, so the free sectors always form one
// run that starts at a pointer; a write takes sectors from that run, one per
// cycle, then closes the list. Results leave one per sector, each after a read
// of the sector list memory, which has a registered read port. A request that
// ends in a single result (miss, delete, no free entry) goes from the decision
// straight to that result; a lookup reads and sends each sector in turn, and a
// write first allocates its sectors and then does the same. Each result shows on the ports
// the cycle after it is formed, the last one in the first cycle with busy_o low.
// Results are strobed by result_valid_o for one cycle and cannot be stalled.
// Writing reserved_sectors resets the free-sector pointer and is taken only
// while idle.
module file_directory_sector_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [47:0] file_name_i,
  input  logic [5:0]  sector_count_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [7:0]  sector_number_o,
  output logic        sector_valid_o,
  output logic [1:0]  status_o,
  output logic [4:0]  sector_total_o,
  output logic        last_o
);

  fdsa_pkg::state_e state_q, state_d;

  logic [fdsa_pkg::NameW-1:0]   names_q [fdsa_pkg::DirEntries];
  logic [fdsa_pkg::CountW-1:0]  len_q   [fdsa_pkg::DirEntries];
  logic [fdsa_pkg::SecW-1:0]    list_mem [fdsa_pkg::ListDepth];

  // lowest free sector; every sector from here up to the end of the map is free
  logic [fdsa_pkg::SecIdxW-1:0] first_free_q;

  fdsa_pkg::action_e            act_q;
  logic [fdsa_pkg::NameW-1:0]   name_q;
  logic [fdsa_pkg::CountW-1:0]  cnt_q;
  logic [fdsa_pkg::EntryW-1:0]  idx_q;
  logic                         found_q, free_q;
  logic [fdsa_pkg::EntryW-1:0]  match_q, fre_q, ent_q;
  logic [fdsa_pkg::SecIdxW-1:0] sec_q;
  logic [fdsa_pkg::CountW-1:0]  got_q, k_q;
  fdsa_pkg::status_e            stat_q;
  logic [fdsa_pkg::SecW-1:0]    rdata_q;

  logic [fdsa_pkg::CountW-1:0]  cnt_sat;
  logic [fdsa_pkg::AddrW-1:0]   wr_addr, rd_addr;
  logic [fdsa_pkg::SecIdxW-1:0] cfg_first;
  logic                         alloc_end, emit_last, do_write, take;

  assign cnt_sat = (sector_count_i > 6'(fdsa_pkg::SectorsPerFile))
                 ? fdsa_pkg::CountW'(fdsa_pkg::SectorsPerFile)
                 : sector_count_i[fdsa_pkg::CountW-1:0];
  assign wr_addr = fdsa_pkg::AddrW'(ent_q * fdsa_pkg::SectorsPerFile)
                 + fdsa_pkg::AddrW'(got_q);
  assign rd_addr = fdsa_pkg::AddrW'(ent_q * fdsa_pkg::SectorsPerFile)
                 + fdsa_pkg::AddrW'(k_q);
  // sector zero ends a list, so it is never handed out
  assign cfg_first = (cfg_data_i == '0) ? 9'd1 : cfg_data_i;
  assign alloc_end = (got_q == cnt_q) || (sec_q >= 9'(fdsa_pkg::MapSectors));
  assign emit_last = (got_q == '0) || (k_q == got_q - 5'd1);
  assign take      = start_i && !busy_o;
  assign do_write  = (state_q == fdsa_pkg::SAlloc) && !alloc_end;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fdsa_pkg::SIdle: begin
        if (take && (action_i != fdsa_pkg::ActNone)) state_d = fdsa_pkg::SFind;
      end
      fdsa_pkg::SFind: begin
        if (idx_q == fdsa_pkg::EntryW'(fdsa_pkg::DirEntries - 1)) state_d = fdsa_pkg::SDecide;
      end
      fdsa_pkg::SDecide: begin
        unique case (act_q)
          fdsa_pkg::ActLookup: state_d = found_q ? fdsa_pkg::SRead : fdsa_pkg::SOne;
          fdsa_pkg::ActWrite:  state_d = (found_q || free_q) ? fdsa_pkg::SAlloc
                                                             : fdsa_pkg::SOne;
          default:             state_d = fdsa_pkg::SOne;
        endcase
      end
      fdsa_pkg::SAlloc: begin
        if (alloc_end) state_d = fdsa_pkg::SRead;
      end
      fdsa_pkg::SRead: state_d = fdsa_pkg::SEmit;
      fdsa_pkg::SEmit: state_d = emit_last ? fdsa_pkg::SIdle : fdsa_pkg::SRead;
      fdsa_pkg::SOne:  state_d = fdsa_pkg::SIdle;
      default:         state_d = fdsa_pkg::SIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy_o      = (state_q != fdsa_pkg::SIdle);
    cfg_ready_o = (state_q == fdsa_pkg::SIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdsa_pkg::SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // sector list store, no reset; only the prefix given by len_q is ever used
  always_ff @(posedge clk_i) begin
    if (do_write) list_mem[wr_addr] <= sec_q[fdsa_pkg::SecW-1:0];
    if (state_q == fdsa_pkg::SRead) rdata_q <= list_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fdsa_pkg::DirEntries; i++) begin
        names_q[i] <= '0;
        len_q[i]   <= '0;
      end
      first_free_q   <= fdsa_pkg::ResetReserved;
      act_q          <= fdsa_pkg::ActNone;
      name_q         <= '0;
      cnt_q          <= '0;
      idx_q          <= '0;
      found_q        <= 1'b0;
      free_q         <= 1'b0;
      match_q        <= '0;
      fre_q          <= '0;
      ent_q          <= '0;
      sec_q          <= '0;
      got_q          <= '0;
      k_q            <= '0;
      stat_q         <= fdsa_pkg::StOk;
      result_valid_o <= 1'b0;
      sector_number_o <= '0;
      sector_valid_o <= 1'b0;
      status_o       <= '0;
      sector_total_o <= '0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= (state_q == fdsa_pkg::SEmit) || (state_q == fdsa_pkg::SOne);
      if (cfg_valid_i && cfg_ready_o) begin
        first_free_q <= cfg_first;
      end
      unique case (state_q)
        fdsa_pkg::SIdle: begin
          if (take) begin
            act_q   <= fdsa_pkg::action_e'(action_i);
            name_q  <= file_name_i;
            cnt_q   <= cnt_sat;
            idx_q   <= '0;
            found_q <= 1'b0;
            free_q  <= 1'b0;
          end
        end
        fdsa_pkg::SFind: begin
          if (!found_q && names_q[idx_q] == name_q) begin
            found_q <= 1'b1;
            match_q <= idx_q;
          end
          if (!free_q && names_q[idx_q][7:0] == 8'h00) begin
            free_q <= 1'b1;
            fre_q  <= idx_q;
          end
          idx_q <= idx_q + 1'b1;
        end
        fdsa_pkg::SDecide: begin
          ent_q <= found_q ? match_q : fre_q;
          k_q   <= '0;
          got_q <= (act_q == fdsa_pkg::ActLookup) ? len_q[match_q] : '0;
          sec_q <= first_free_q;
          unique case (act_q)
            fdsa_pkg::ActLookup: begin
              stat_q <= found_q ? fdsa_pkg::StOk : fdsa_pkg::StNotFound;
            end
            fdsa_pkg::ActWrite: begin
              stat_q <= fdsa_pkg::StNoEntry;
              if (found_q || free_q) names_q[found_q ? match_q : fre_q] <= name_q;
            end
            default: begin
              stat_q <= found_q ? fdsa_pkg::StOk : fdsa_pkg::StNotFound;
              if (found_q) begin
                names_q[match_q][7:0] <= 8'h00;
                len_q[match_q]        <= '0;
              end
            end
          endcase
        end
        fdsa_pkg::SAlloc: begin
          if (alloc_end) begin
            len_q[ent_q] <= got_q;
            first_free_q <= sec_q;
            stat_q <= (got_q < cnt_q) ? fdsa_pkg::StShort : fdsa_pkg::StOk;
          end else begin
            got_q <= got_q + 1'b1;
            sec_q <= sec_q + 1'b1;
          end
        end
        fdsa_pkg::SRead: begin
        end
        fdsa_pkg::SEmit: begin
          sector_valid_o  <= (k_q < got_q);
          sector_number_o <= (k_q < got_q) ? rdata_q : 8'h00;
          status_o        <= stat_q;
          sector_total_o  <= emit_last ? got_q : '0;
          last_o          <= emit_last;
          k_q             <= k_q + 1'b1;
        end
        fdsa_pkg::SOne: begin
          sector_valid_o  <= 1'b0;
          sector_number_o <= 8'h00;
          status_o        <= stat_q;
          sector_total_o  <= '0;
          last_o          <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: verif/file_directory_sector_allocator_test.sv
// Testbench for file_directory_sector_allocator: directed and random directory requests
// checked against a behavioral directory and sector-map predictor. Depends on fdsa_pkg.
module file_directory_sector_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] sector;
    logic       valid;
    logic [1:0] status;
    logic [4:0] total;
    logic       last;
  } sector_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  action_i = fdsa_pkg::ActLookup;
  logic [47:0] file_name_i = '0;
  logic [5:0]  sector_count_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i = '0;
  logic        result_valid_o;
  logic [7:0]  sector_number_o;
  logic        sector_valid_o;
  logic [1:0]  status_o;
  logic [4:0]  sector_total_o;
  logic        last_o;

  file_directory_sector_allocator dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // directory and sector-map shadow
  logic [8:0]  reserve_limit;
  logic [47:0] dir_names [fdsa_pkg::DirEntries];
  logic [7:0]  dir_sectors [fdsa_pkg::DirEntries][fdsa_pkg::SectorsPerFile];
  logic        map_used [fdsa_pkg::MapSectors];

  sector_report_t pending_reports[$];
  int  fail_count = 0;
  int  quiet_cycles = 0;
  bit  steady_sender = 0;
  logic [47:0] known_names[$];

  task automatic init_map();
    for (int s = 0; s < fdsa_pkg::MapSectors; s++) map_used[s] = (s < reserve_limit);
  endtask

  function automatic int find_entry(logic [47:0] name);
    for (int i = 0; i < fdsa_pkg::DirEntries; i++) if (dir_names[i] == name) return i;
    return -1;
  endfunction

  task automatic push_report(logic [7:0] sec, logic v, fdsa_pkg::status_e st,
                             logic [4:0] tot, logic l);
    sector_report_t r;
    r.sector = sec; r.valid = v; r.status = st; r.total = tot; r.last = l;
    pending_reports.push_back(r);
  endtask

  task automatic push_list(int e, int got, fdsa_pkg::status_e st);
    int n;
    n = (got == 0) ? 1 : got;
    for (int k = 0; k < n; k++)
      push_report(k < got ? dir_sectors[e][k] : 8'd0, k < got, st,
                  k == n - 1 ? got[4:0] : 5'd0, k == n - 1);
  endtask

  task automatic predict_request(fdsa_pkg::action_e act, logic [47:0] name,
                                 logic [5:0] cnt_in);
    int e, got, cnt;
    e = find_entry(name);
    cnt = (cnt_in > fdsa_pkg::SectorsPerFile) ? fdsa_pkg::SectorsPerFile : cnt_in;
    case (act)
      fdsa_pkg::ActLookup: begin
        if (e < 0) push_report(8'd0, 1'b0, fdsa_pkg::StNotFound, 5'd0, 1'b1);
        else begin
          got = 0;
          while (got < fdsa_pkg::SectorsPerFile && dir_sectors[e][got] != 8'd0) got++;
          push_list(e, got, fdsa_pkg::StOk);
        end
      end
      fdsa_pkg::ActWrite: begin
        if (e < 0)
          for (int i = 0; i < fdsa_pkg::DirEntries; i++)
            if (dir_names[i][7:0] == 8'h00) begin
              e = i;
              break;
            end
        if (e < 0) push_report(8'd0, 1'b0, fdsa_pkg::StNoEntry, 5'd0, 1'b1);
        else begin
          dir_names[e] = name;
          for (int k = 0; k < fdsa_pkg::SectorsPerFile; k++) dir_sectors[e][k] = 8'd0;
          got = 0;
          for (int s = 1; s < fdsa_pkg::MapSectors && got < cnt; s++)
            if (!map_used[s]) begin
              map_used[s] = 1'b1;
              dir_sectors[e][got] = s[7:0];
              got++;
            end
          push_list(e, got, got < cnt ? fdsa_pkg::StShort : fdsa_pkg::StOk);
        end
      end
      fdsa_pkg::ActDelete: begin
        if (e < 0) push_report(8'd0, 1'b0, fdsa_pkg::StNotFound, 5'd0, 1'b1);
        else begin
          for (int k = 0; k < fdsa_pkg::SectorsPerFile; k++) dir_sectors[e][k] = 8'd0;
          dir_names[e][7:0] = 8'h00;
          push_report(8'd0, 1'b0, fdsa_pkg::StOk, 5'd0, 1'b1);
        end
      end
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    if (!steady_sender && $urandom_range(99) < 32)
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic send_request(fdsa_pkg::action_e act, logic [47:0] name, logic [5:0] cnt);
    idle_gap();
    start_i <= 1'b1;
    action_i <= act;
    file_name_i <= name;
    sector_count_i <= cnt;
    do @(posedge clk_i); while (busy_o);
    predict_request(act, name, cnt);
    start_i <= 1'b0;
    action_i <= 2'($urandom_range(3));
    file_name_i <= 48'({$urandom, $urandom});
    // hold start low for one cycle; the block is busy then unless the action was unused
    @(posedge clk_i);
  endtask

  task automatic drain_reports();
    while (pending_reports.size() != 0) @(posedge clk_i);
    // an unused action leaves no result, so give the block time to settle
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reserve(logic [8:0] value);
    drain_reports();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    reserve_limit = value;
    init_map();
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [47:0] pick_name();
    if (known_names.size() != 0 && $urandom_range(99) < 70)
      return known_names[$urandom_range(known_names.size() - 1)];
    return 48'({$urandom, $urandom});
  endfunction

  // check each strobed result
  always @(posedge clk_i) begin
    sector_report_t got, want;
    if (rst_ni && result_valid_o) begin
      got = {sector_number_o, sector_valid_o, status_o, sector_total_o, last_o};
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.sector !== want.sector)
          $display("%0t: sector expected %0d actual %0d", $time, want.sector, got.sector);
        if (got.valid !== want.valid)
          $display("%0t: valid expected %0d actual %0d", $time, want.valid, got.valid);
        if (got.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.total !== want.total)
          $display("%0t: total expected %0d actual %0d", $time, want.total, got.total);
        if (got.last !== want.last)
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want) fail_count++;
      end
    end
  end

  // watchdog: no request, result or register write for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed();
    logic [47:0] nm;
    nm = 48'hFFFF_FFFF_FFFF;
    send_request(fdsa_pkg::ActLookup, nm, 6'd0);
    send_request(fdsa_pkg::ActDelete, nm, 6'd0);
    send_request(fdsa_pkg::ActWrite, nm, 6'd63);
    send_request(fdsa_pkg::ActLookup, nm, 6'd0);
    send_request(fdsa_pkg::ActWrite, nm, 6'd2);
    send_request(fdsa_pkg::ActLookup, nm, 6'd0);
    send_request(fdsa_pkg::ActWrite, 48'h0000_0000_0001, 6'd0);
    send_request(fdsa_pkg::ActLookup, 48'h0000_0000_0001, 6'd0);
    send_request(fdsa_pkg::ActDelete, nm, 6'd0);
    send_request(fdsa_pkg::ActLookup, nm, 6'd0);
    send_request(fdsa_pkg::ActLookup, 48'h0, 6'd0);
    send_request(fdsa_pkg::ActWrite, 48'hAB00, 6'd1);
    send_request(fdsa_pkg::ActNone, nm, 6'd5);
    send_request(fdsa_pkg::ActDelete, 48'hAB00, 6'd0);
    for (int i = 0; i < 17; i++)
      send_request(fdsa_pkg::ActWrite, 48'h5A00 + i + 1, 6'd26);
    send_request(fdsa_pkg::ActLookup, 48'h5A01 + 9, 6'd0);
  endtask

  task automatic test_reserve_extremes();
    write_reserve(9'd256);
    send_request(fdsa_pkg::ActDelete, 48'h5A03, 6'd0);
    send_request(fdsa_pkg::ActWrite, 48'h5A03, 6'd4);
    write_reserve(9'd1);
    send_request(fdsa_pkg::ActWrite, 48'h5A05, 6'd3);
    write_reserve(9'd511);
    send_request(fdsa_pkg::ActWrite, 48'h5A05, 6'd3);
    write_reserve(9'd250);
    send_request(fdsa_pkg::ActWrite, 48'h5A06, 6'd26);
  endtask

  task automatic test_random(int items);
    fdsa_pkg::action_e act;
    logic [47:0] nm;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) drain_reports();
      steady_sender = (n >= 20 && n < 45);
      if (n % 30 == 29) write_reserve(9'($urandom_range(1, 40)));
      case ($urandom_range(9))
        0, 1, 2, 3: act = fdsa_pkg::ActWrite;
        4, 5, 6:    act = fdsa_pkg::ActLookup;
        7, 8:       act = fdsa_pkg::ActDelete;
        default:    act = fdsa_pkg::ActNone;
      endcase
      nm = pick_name();
      if (act == fdsa_pkg::ActWrite && known_names.size() < 24) known_names.push_back(nm);
      send_request(act, nm, $urandom_range(99) < 80 ? 6'($urandom_range(0, 8))
                                                     : 6'($urandom_range(0, 63)));
    end
    steady_sender = 0;
  endtask

  initial begin
    reserve_limit = fdsa_pkg::ResetReserved;
    for (int i = 0; i < fdsa_pkg::DirEntries; i++) begin
      dir_names[i] = '0;
      for (int k = 0; k < fdsa_pkg::SectorsPerFile; k++) dir_sectors[i][k] = '0;
    end
    init_map();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reserve_extremes();
    write_reserve(9'd3);
    test_random(75);
    drain_reports();
    if (fail_count == 0 && pending_reports.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
